// File: rtl/dbd_pkg.sv
// Shared types, constants and date helper functions for the days-between-dates block.
// No dependencies; imported by dbd_date and days_between_dates.
`default_nettype none

package dbd_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int DAYNUM_W = 22;
	localparam int DIFF_W   = 23;

	localparam logic [YEAR_W-1:0]   YEAR_MAX        = 14'd9999;
	localparam logic [MONTH_W-1:0]  MONTHS_PER_YEAR = 4'd12;
	localparam logic [MONTH_W-1:0]  MARCH           = 4'd3;
	// Day number of 1/1/2000, the substitute for an invalid date
	localparam logic [DAYNUM_W-1:0] DEFAULT_DAY_NUM = 22'd730425;

	typedef struct packed {
		logic                valid;
		logic [DAYNUM_W-1:0] day_num;
	} date_info_t;

	// Floor of y / 100 by reciprocal multiply; exact for all 14-bit y
	function automatic logic [7:0] div100(input logic [YEAR_W-1:0] y);
		logic [26:0] prod;
		prod = 27'(y) * 27'd5243;
		return prod[26:19];
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd30;
		endcase
		return len;
	endfunction

	// Days before the first of month m, counting from March; m runs 3 to 14
	function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [8:0] off;
		case (m)
			4'd3:  off = 9'd0;
			4'd4:  off = 9'd31;
			4'd5:  off = 9'd61;
			4'd6:  off = 9'd92;
			4'd7:  off = 9'd122;
			4'd8:  off = 9'd153;
			4'd9:  off = 9'd184;
			4'd10: off = 9'd214;
			4'd11: off = 9'd245;
			4'd12: off = 9'd275;
			4'd13: off = 9'd306;
			4'd14: off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

`default_nettype wire

// File: rtl/days_between_dates.sv
// Days between two Gregorian dates. Each request carries two dates (day, month, year);
// each is checked with the leap-year and month-length rules, and an invalid one
// (including year 0 or above 9999) is replaced by 1/1/2000. The result gives both
// validity flags and the signed day count, second date minus first. A request passes
// through an input register, the date conversion logic, and a result register. One
// request is taken every cycle while results are drained; the rate is set by the
// single pass through the two dbd_date converters.
// Depends on dbd_pkg and dbd_date.
`default_nettype none

module days_between_dates import dbd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [DAY_W-1:0]         first_day,
	input  logic [MONTH_W-1:0]       first_month,
	input  logic [YEAR_W-1:0]        first_year,
	input  logic [DAY_W-1:0]         second_day,
	input  logic [MONTH_W-1:0]       second_month,
	input  logic [YEAR_W-1:0]        second_year,

	output logic                     res_valid,
	input  logic                     res_stall,
	output logic                     first_valid,
	output logic                     second_valid,
	output logic signed [DIFF_W-1:0] day_difference
);

	logic                req_valid_s1;
	logic [DAY_W-1:0]    first_day_s1;
	logic [MONTH_W-1:0]  first_month_s1;
	logic [YEAR_W-1:0]   first_year_s1;
	logic [DAY_W-1:0]    second_day_s1;
	logic [MONTH_W-1:0]  second_month_s1;
	logic [YEAR_W-1:0]   second_year_s1;

	logic                res_valid_s2;
	logic                first_valid_s2;
	logic                second_valid_s2;
	logic [DIFF_W-1:0]   diff_s2;

	logic                res_ready;
	logic                req_accept;
	date_info_t          first_info;
	date_info_t          second_info;

	assign res_ready  = !res_valid_s2 || !res_stall;
	assign req_stall  = req_valid_s1 && !res_ready;
	assign req_accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_accept) begin
			req_valid_s1 <= 1'b1;
		end else if (res_ready) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			first_day_s1    <= first_day;
			first_month_s1  <= first_month;
			first_year_s1   <= first_year;
			second_day_s1   <= second_day;
			second_month_s1 <= second_month;
			second_year_s1  <= second_year;
		end
	end

	dbd_date u_first (
		.day   (first_day_s1),
		.month (first_month_s1),
		.year  (first_year_s1),
		.info  (first_info)
	);

	dbd_date u_second (
		.day   (second_day_s1),
		.month (second_month_s1),
		.year  (second_year_s1),
		.info  (second_info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (res_ready) begin
			res_valid_s2 <= req_valid_s1;
		end
	end

	// Hold the result while the consumer stalls
	always_ff @(posedge clk) begin
		if (res_ready && req_valid_s1) begin
			first_valid_s2  <= first_info.valid;
			second_valid_s2 <= second_info.valid;
			diff_s2         <= 23'(second_info.day_num) - 23'(first_info.day_num);
		end
	end

	assign res_valid      = res_valid_s2;
	assign first_valid    = first_valid_s2;
	assign second_valid   = second_valid_s2;
	assign day_difference = signed'(diff_s2);

`ifndef NO_ASSERTIONS
	// Two invalid dates both become 1/1/2000, so the count must be zero
	a_both_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !first_valid && !second_valid |-> day_difference == '0)
		else $error("nonzero day count with both dates invalid");

	// A request is only stalled when both stages are full and the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> req_valid_s1 && res_valid_s2 && res_stall)
		else $error("request stalled without a full pipeline");

	// An accepted request lands in the input stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |=> req_valid_s1)
		else $error("accepted request lost");

	// A held input item moves to the output whenever the output can take it
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 && res_ready |=> res_valid_s2)
		else $error("input stage did not advance");
`endif

endmodule

`default_nettype wire

// File: rtl/dbd_date.sv
// Checks one Gregorian date and converts it to an absolute day number.
// Depends on dbd_pkg; invalid dates map to the day number of 1/1/2000.
`default_nettype none

module dbd_date import dbd_pkg::*; (
	input  logic [DAY_W-1:0]   day,
	input  logic [MONTH_W-1:0] month,
	input  logic [YEAR_W-1:0]  year,
	output date_info_t         info
);

	logic [7:0]          q100;
	logic [6:0]          r100;
	logic                leap;
	logic                ok;
	logic                early;
	logic [YEAR_W-1:0]   year_adj;
	logic [MONTH_W-1:0]  month_adj;
	logic [7:0]          q100_adj;
	logic [DAYNUM_W-1:0] num;

	always_comb begin
		q100 = div100(year);
		r100 = 7'(year - 14'(q100) * 14'd100);
		leap = (year[1:0] == 2'd0) && ((r100 != 7'd0) || (q100[1:0] == 2'd0));

		ok = (year != '0) && (year <= YEAR_MAX)
			&& (month != '0) && (month <= MONTHS_PER_YEAR)
			&& (day != '0) && (day <= month_len(month, leap));

		// January and February count as months 13 and 14 of the previous year
		early     = month < MARCH;
		year_adj  = early ? year - 14'd1 : year;
		month_adj = early ? month + MONTHS_PER_YEAR : month;
		q100_adj  = div100(year_adj);

		num = 22'(year_adj) * 22'd365
			+ 22'(year_adj[YEAR_W-1:2])
			- 22'(q100_adj)
			+ 22'(q100_adj[7:2])
			+ 22'(month_offset(month_adj))
			+ 22'(day) - 22'd1;

		info.valid   = ok;
		info.day_num = ok ? num : DEFAULT_DAY_NUM;
	end

endmodule

`default_nettype wire
